// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Operation codes, controller command bundle and datapath status bundle.
// ----------------------------------------------------------------------------
package rau_pkg;

	// operation codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_INC = 3'd5;
	localparam logic [2:0] OP_DEC = 3'd6;
	localparam logic [2:0] OP_CMP = 3'd7;

	// result widths fixed by the interface
	localparam int RES_W = 64;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture operands
		logic mul1;      // first cross product
		logic mul2;      // second cross product / denominator
		logic combine;   // form numerator and denominator magnitudes
		logic div_init;  // start a divider pass
		logic div_step;  // one restoring-division bit
		logic gcd_next;  // x <= y, y <= remainder
		logic red_num;   // latch numerator quotient
		logic red_den;   // latch denominator quotient
		logic finish;    // drive result registers
	} rau_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic err;       // zero denominator or zero divisor
		logic mag_zero;  // numerator magnitude is zero
		logic rem_zero;  // gcd remainder zero
		logic div_done;  // divider finished its bits
	} rau_sts_t;

endpackage

// ===== src/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, divider and gcd regs
// One 32x32 multiplier is reused, a second forms ad*bd, and one restoring
// 64-bit divider serves the Euclid remainders and both final reductions.
// ----------------------------------------------------------------------------
module rau_datapath
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rau_cmd_t                 cmd,
	input  logic [1:0]               div_sel,
	output rau_sts_t                 sts,
	input  logic [2:0]               operation,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-2:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-2:0] b_den,
	output logic [RES_W-1:0]         res_num,
	output logic [RES_W-2:0]         res_den,
	output logic                     less,
	output logic                     equal,
	output logic                     greater,
	output logic                     status
);

	localparam int W  = OPERAND_WIDTH;
	localparam int CW = $clog2(RES_W + 1);

	// operand registers, numerators sign-extended and denominators zero-extended to 64 bits
	logic [2:0]       op_q;
	logic [RES_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic             err_q;
	logic [RES_W-1:0] p1_q, p2_q;
	logic [RES_W-1:0] mag_q, den_q;
	logic             neg_q, lt_q, eq_q, gt_q;
	logic [RES_W-1:0] x_q, y_q;
	logic [RES_W-1:0] qt_q, rm_q, dvd_q, dvs_q;
	logic [CW-1:0]    cnt_q;
	logic [RES_W-1:0] qn_q;

	logic uses_b;
	assign uses_b = (operation != OP_NEG) && (operation != OP_INC) && (operation != OP_DEC);

	// operand capture and argument checks
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			an_q  <= RES_W'(signed'(a_num));
			ad_q  <= RES_W'(a_den);
			bn_q  <= RES_W'(signed'(b_num));
			bd_q  <= RES_W'(b_den);
			err_q <= (a_den == '0) || (uses_b && b_den == '0) ||
				(operation == OP_DIV && b_num == '0);
		end
	end

	// shared signed multiplier, operands are at most 32 bits
	logic signed [RES_W-1:0] m_a, m_b;
	logic signed [RES_W-1:0] m_p;
	always_comb begin
		m_a = signed'(an_q);
		m_b = signed'(bd_q);
		if (cmd.mul2) begin
			case (op_q)
				OP_MUL: begin m_a = signed'(an_q); m_b = signed'(bn_q); end
				OP_DIV: begin m_a = signed'(ad_q); m_b = signed'(bn_q); end
				default: begin m_a = signed'(bn_q); m_b = signed'(ad_q); end
			endcase
		end
	end
	assign m_p = signed'(W'(m_a)) * signed'(W'(m_b));

	// denominator product for add/sub/cmp/mul, full width of both operands
	logic [2*W-3:0]   dd_p;
	logic [RES_W-1:0] dd;
	assign dd_p = ad_q[W-2:0] * bd_q[W-2:0];
	assign dd   = RES_W'(dd_p);

	always_ff @(posedge clk) begin
		if (cmd.mul1) p1_q <= m_p;
		if (cmd.mul2) p2_q <= m_p;
	end

	// numerator and denominator in signed form
	logic signed [RES_W-1:0] n_s, d_s;
	always_comb begin
		case (op_q)
			OP_ADD:  begin n_s = p1_q + p2_q; d_s = dd; end
			OP_MUL:  begin n_s = p2_q;        d_s = dd; end
			OP_DIV:  begin n_s = p1_q;        d_s = p2_q; end
			OP_NEG:  begin n_s = -an_q;       d_s = ad_q; end
			OP_INC:  begin n_s = an_q + ad_q; d_s = ad_q; end
			OP_DEC:  begin n_s = an_q - ad_q; d_s = ad_q; end
			default: begin n_s = p1_q - p2_q; d_s = dd; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.combine) begin
			mag_q <= n_s[RES_W-1] ? RES_W'(-n_s) : n_s;
			den_q <= d_s[RES_W-1] ? RES_W'(-d_s) : d_s;
			neg_q <= n_s[RES_W-1] ^ d_s[RES_W-1];
			lt_q  <= n_s[RES_W-1];
			eq_q  <= n_s == '0;
			gt_q  <= !n_s[RES_W-1] && n_s != '0;
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [RES_W:0] trial;
	assign trial = {rm_q, dvd_q[RES_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			case (div_sel)
				2'd1:    begin dvd_q <= mag_q; dvs_q <= x_q; end
				2'd2:    begin dvd_q <= den_q; dvs_q <= x_q; end
				default: begin dvd_q <= x_q;   dvs_q <= y_q; end
			endcase
			rm_q  <= '0;
			qt_q  <= '0;
			cnt_q <= CW'(RES_W);
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q - 1'b1;
			if (!trial[RES_W]) begin
				rm_q <= trial[RES_W-1:0];
				qt_q <= {qt_q[RES_W-2:0], 1'b1};
			end else begin
				rm_q <= {rm_q[RES_W-2:0], dvd_q[RES_W-1]};
				qt_q <= {qt_q[RES_W-2:0], 1'b0};
			end
		end
	end

	// Euclid registers
	always_ff @(posedge clk) begin
		if (cmd.combine) begin
			x_q <= n_s[RES_W-1] ? RES_W'(-n_s) : n_s;
			y_q <= d_s[RES_W-1] ? RES_W'(-d_s) : d_s;
		end else if (cmd.gcd_next) begin
			x_q <= y_q;
			y_q <= rm_q;
		end
		if (cmd.red_num) qn_q <= qt_q;
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_num <= '0;
			res_den <= '0;
			less    <= 1'b0;
			equal   <= 1'b0;
			greater <= 1'b0;
			status  <= 1'b0;
		end else if (cmd.finish) begin
			less    <= 1'b0;
			equal   <= 1'b0;
			greater <= 1'b0;
			status  <= 1'b0;
			if (err_q) begin
				res_num <= '0;
				res_den <= '0;
				status  <= 1'b1;
			end else begin
				if (mag_q == '0) begin
					res_num <= '0;
					res_den <= (RES_W-1)'(1);
				end else begin
					res_num <= neg_q ? RES_W'(-qn_q) : qn_q;
					res_den <= qt_q[RES_W-2:0];
				end
				if (op_q == OP_CMP) begin
					less    <= lt_q;
					equal   <= eq_q;
					greater <= gt_q;
				end
			end
		end
	end

	assign sts.err      = err_q;
	assign sts.mag_zero = mag_q == '0;
	assign sts.rem_zero = rm_q == '0;
	assign sts.div_done = cnt_q == '0;

endmodule

// ===== src/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational arithmetic unit
// Steps products, Euclid loop and the two reductions through the datapath.
// ----------------------------------------------------------------------------
module rau_ctrl
	import rau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	input  rau_sts_t  sts,
	output rau_cmd_t  cmd,
	output logic [1:0] div_sel
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_MUL1 = 10'b0000000010,
		S_MUL2 = 10'b0000000100,
		S_COMB = 10'b0000001000,
		S_GINI = 10'b0000010000,
		S_GDIV = 10'b0000100000,
		S_RINI = 10'b0001000000,
		S_RDIV = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   den_pass_q, den_pass_d;

	// next-state and command decode
	always_comb begin
		state_d    = state_q;
		den_pass_d = den_pass_q;
		cmd        = '0;
		div_sel    = den_pass_q ? 2'd2 : 2'd1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_MUL1;
				end
			end
			S_MUL1: begin cmd.mul1 = 1'b1; state_d = S_MUL2; end
			S_MUL2: begin cmd.mul2 = 1'b1; state_d = S_COMB; end
			S_COMB: begin
				cmd.combine = 1'b1;
				state_d     = S_GINI;
			end
			S_GINI: begin
				if (sts.err || sts.mag_zero) begin
					state_d = S_FIN;
				end else begin
					div_sel      = 2'd0;
					cmd.div_init = 1'b1;
					state_d      = S_GDIV;
				end
			end
			S_GDIV: begin
				if (sts.div_done) begin
					cmd.gcd_next = 1'b1;
					state_d      = sts.rem_zero ? S_RINI : S_GINI;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_RINI: begin
				cmd.div_init = 1'b1;
				state_d      = S_RDIV;
			end
			S_RDIV: begin
				if (sts.div_done) begin
					if (den_pass_q) begin
						den_pass_d = 1'b0;
						state_d    = S_FIN;
					end else begin
						cmd.red_num = 1'b1;
						den_pass_d  = 1'b1;
						state_d     = S_RINI;
					end
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			den_pass_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			den_pass_q <= den_pass_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

endmodule

// ===== src/rational_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: reduced fraction add/sub/mul/div/cmp
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
//  channel   signals                               transfer when
//  command   start, operation, a_*, b_*            start && !busy
//  result    done, res_*, less/equal/greater, status   done high
//
// An item runs the products, then k Euclid steps (up to about 90) and two
// reductions on the single 64-bit restoring divider that runs one bit a cycle.
// Errors and zero results skip the Euclid loop and the reductions.
// Reset clears the sequencer and result registers; busy is low after reset.
// The receiver cannot stall: done is high for one cycle per item.
module rational_arithmetic_unit_core
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               operation,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-2:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-2:0] b_den,
	output logic                     done,
	output logic [RES_W-1:0]         res_num,
	output logic [RES_W-2:0]         res_den,
	output logic                     less,
	output logic                     equal,
	output logic                     greater,
	output logic                     status
);

	rau_cmd_t   cmd;
	rau_sts_t   sts;
	logic [1:0] div_sel;

	rau_ctrl u_ctrl (
		.clk, .arst_n, .start, .busy, .done, .sts, .cmd, .div_sel
	);

	rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .div_sel, .sts, .operation, .a_num, .a_den,
		.b_num, .b_den, .res_num, .res_den, .less, .equal, .greater, .status
	);

endmodule

// ===== src/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_port_checks: port-level checks for the rational arithmetic unit
// Bound to the top level.
// ----------------------------------------------------------------------------
module rau_port_checks (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic less,
	input logic equal,
	input logic greater,
	input logic status
);

	// an accepted command makes the unit busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");

	// a result ends the item
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");

	// done is a single-cycle strobe
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done too long");

	// at most one compare flag, none on error
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({less, equal, greater}) && !(status && (less || equal || greater)))
		else $error("bad flags");

endmodule

bind rational_arithmetic_unit_core rau_port_checks u_rau_port_checks (
	.clk, .arst_n, .start, .busy, .done, .less, .equal, .greater, .status
);

// ===== tb/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker: result predictor and scoreboard for the rational unit
// Watches command transfers, computes the reduced fraction and compare
// flags for each one, and matches every done strobe against the oldest one.
// ----------------------------------------------------------------------------
module rau_checker
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [2:0]               operation,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-2:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-2:0] b_den,
	input  logic                     done,
	input  logic [RES_W-1:0]         res_num,
	input  logic [RES_W-2:0]         res_den,
	input  logic                     less,
	input  logic                     equal,
	input  logic                     greater,
	input  logic                     status,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic [RES_W-1:0] num;
		logic [RES_W-2:0] den;
		logic             lt;
		logic             eq;
		logic             gt;
		logic             err;
	} fraction_t;

	fraction_t fractions_due[$];

	function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// exact reduced result of one command
	function automatic fraction_t reduce_fraction(logic [2:0] op,
			logic [OPERAND_WIDTH-1:0] an_f, logic [OPERAND_WIDTH-2:0] ad_f,
			logic [OPERAND_WIDTH-1:0] bn_f, logic [OPERAND_WIDTH-2:0] bd_f);
		fraction_t r;
		longint an, ad, bn, bd, n, d;
		longint unsigned mag, dmag, g;
		logic with_b, neg;
		an = longint'($signed(an_f));
		bn = longint'($signed(bn_f));
		ad = longint'(ad_f);
		bd = longint'(bd_f);
		r = '0;
		with_b = (op <= OP_DIV) || (op == OP_CMP);
		if (ad == 0 || (with_b && bd == 0) || (op == OP_DIV && bn == 0)) begin
			r.err = 1'b1;
			return r;
		end
		case (op)
			OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
			OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
			OP_MUL: begin n = an * bn; d = ad * bd; end
			OP_DIV: begin n = an * bd; d = ad * bn; end
			OP_NEG: begin n = -an; d = ad; end
			OP_INC: begin n = an + ad; d = ad; end
			OP_DEC: begin n = an - ad; d = ad; end
			default: begin n = an * bd - bn * ad; d = ad * bd; end
		endcase
		neg = (n < 0) != (d < 0);
		mag = (n < 0) ? -n : n;
		dmag = (d < 0) ? -d : d;
		if (mag == 0) begin
			r.num = '0;
			r.den = (RES_W-1)'(1);
		end else begin
			g = euclid(mag, dmag);
			mag = mag / g;
			dmag = dmag / g;
			r.num = neg ? -mag : mag;
			r.den = dmag[RES_W-2:0];
		end
		if (op == OP_CMP) begin
			r.lt = n < 0;
			r.eq = n == 0;
			r.gt = n > 0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [RES_W-1:0] got,
			logic [RES_W-1:0] want);
		$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// command transfers in, results out
	always @(posedge clk) begin
		fraction_t e;
		if (arst_n) begin
			if (start && !busy)
				fractions_due.push_back(reduce_fraction(operation, a_num, a_den,
					b_num, b_den));
			if (done) begin
				if (fractions_due.size() == 0) begin
					$display("MISMATCH at %0t: result with no command waiting", $realtime);
					fail_count++;
				end else begin
					e = fractions_due.pop_front();
					if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
					if (res_den !== e.den)
						report_mismatch("res_den", RES_W'(res_den), RES_W'(e.den));
					if (less !== e.lt) report_mismatch("less", RES_W'(less), RES_W'(e.lt));
					if (equal !== e.eq)
						report_mismatch("equal", RES_W'(equal), RES_W'(e.eq));
					if (greater !== e.gt)
						report_mismatch("greater", RES_W'(greater), RES_W'(e.gt));
					if (status !== e.err)
						report_mismatch("status", RES_W'(status), RES_W'(e.err));
				end
			end
		end
		pending = fractions_due.size();
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for rational_arithmetic_unit_core
// Directed corner commands, then random fractions of mixed magnitude, with
// random gaps between transfers or none in bursts; checking is done in rau_checker.
// ----------------------------------------------------------------------------
module testbench;
	import rau_pkg::*;

	localparam int W = 32;
	localparam int N_RANDOM = 830;
	localparam longint CYCLE_LIMIT = 40000000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	logic [2:0]     operation = OP_ADD;
	logic [W-1:0]   a_num = '0;
	logic [W-2:0]   a_den = 1;
	logic [W-1:0]   b_num = '0;
	logic [W-2:0]   b_den = 1;
	logic           done;
	logic [RES_W-1:0] res_num;
	logic [RES_W-2:0] res_den;
	logic           less, equal, greater, status;
	int             fail_count, pending;
	longint         cycles = 0;
	bit             burst = 0;

	always #6 clk = ~clk;

	rational_arithmetic_unit_core #(.OPERAND_WIDTH(W)) DUT (.*);

	rau_checker #(.OPERAND_WIDTH(W)) u_checker (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one command transfer, after a random gap unless in a burst
	task automatic issue(logic [2:0] op, logic [W-1:0] an, logic [W-2:0] ad,
			logic [W-1:0] bn, logic [W-2:0] bd);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [W-1:0] rand_num();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return {1'b1, {(W-1){1'b0}}};
			2: return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-2){1'b0}}, 1'b1};
			3: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [W-2:0] rand_den();
		case ($urandom_range(0, 5))
			0: return (W-1)'($urandom_range(1, 12));
			1: return {(W-1){1'b1}};
			2: return $urandom_range(0, 30) == 0 ? '0 : (W-1)'($urandom_range(1, 1000));
			3: return {1'($urandom_range(0, 1)), {(W-2){1'b0}}} | (W-1)'(1);
			default: return (W-1)'($urandom);
		endcase
	endfunction

	logic [W-1:0] most_neg = {1'b1, {(W-1){1'b0}}};
	logic [W-1:0] most_pos = {1'b0, {(W-1){1'b1}}};
	logic [W-2:0] den_max = {(W-1){1'b1}};

	initial begin
		logic [2:0] op;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation, extremes, zero denominators, zero divisor
		for (int i = 0; i < 8; i++)
			issue(3'(i), most_pos, den_max, most_neg, 1);
		issue(OP_CMP, 3, 6, 1, 2);
		issue(OP_CMP, -1, 3, 1, 3);
		issue(OP_ADD, 0, 5, 0, 7);
		issue(OP_DIV, 5, 3, 0, 4);
		issue(OP_ADD, 5, 0, 1, 1);
		issue(OP_SUB, 5, 3, 1, 0);
		issue(OP_NEG, 5, 3, 1, 0);
		issue(OP_INC, most_neg, 0, 0, 0);
		issue(OP_NEG, most_neg, 1, 0, 1);
		issue(OP_MUL, most_neg, 1, most_neg, 1);
		issue(OP_DIV, most_neg, den_max, most_neg, den_max);
		issue(OP_DEC, 12, 8, 0, 0);
		issue(OP_CMP, most_neg, 1, most_pos, 1);
		issue(OP_ADD, 6, 4, -2, 4);

		// hold off until everything has drained
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) burst = 1'($urandom_range(0, 1));
			op = 3'($urandom_range(0, 7));
			issue(op, rand_num(), rand_den(), rand_num(), rand_den());
		end
		start <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/rau_pkg.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit_core.sv
src/rau_checker.sv
tb/rau_checker.sv
tb/testbench.sv
